[rtl/rbc_pkg.sv]
package rbc_pkg;

  localparam int TIMER_BITS = 10;
  localparam int CLAMP_BITS = (TIMER_BITS > 10) ? TIMER_BITS : 10;
  localparam logic [TIMER_BITS-1:0] TMR_MAX = {TIMER_BITS{1'b1}};

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_PRESS   = 3'd1,
    EV_RELEASE = 3'd2,
    EV_PULSE   = 3'd3,
    EV_HOLD    = 3'd4
  } event_t;

  typedef enum logic [2:0] {
    CFG_PULSE_TICKS     = 3'd0,
    CFG_HOLD_TICKS      = 3'd1,
    CFG_BLINK_ON_TICKS  = 3'd2,
    CFG_BLINK_OFF_TICKS = 3'd3,
    CFG_BLINK_COUNT     = 3'd4
  } cfg_index_t;

  typedef struct packed {
    logic [9:0] pulse_ticks;
    logic [9:0] hold_ticks;
    logic [7:0] blink_on_ticks;
    logic [7:0] blink_off_ticks;
    logic [2:0] blink_count;
  } cfg_t;

  typedef struct packed {
    logic   ext_reset_pin;
    logic   led_drive;
    logic   led_held;
    logic   reset_request;
    event_t event_code;
  } result_t;

  function automatic logic [TIMER_BITS-1:0] load_tmr(input logic [9:0] v);
    logic [CLAMP_BITS-1:0] ext;
    ext = CLAMP_BITS'(v);
    if (ext == '0) begin
      return TIMER_BITS'(1);
    end else if (ext > CLAMP_BITS'(TMR_MAX)) begin
      return TMR_MAX;
    end
    return ext[TIMER_BITS-1:0];
  endfunction

  function automatic logic [7:0] at_least_one8(input logic [7:0] v);
    return (v == 8'd0) ? 8'd1 : v;
  endfunction

endpackage

[rtl/rbc_core.sv]
module rbc_core
  import rbc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    step,
  input  logic    button,
  input  cfg_t    cfg,
  output result_t res
);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ON   = 2'd1,
    PH_WAIT = 2'd2
  } phase_t;

  logic                  primed, primed_next;
  logic                  last_button, last_button_next;
  phase_t                pulse_phase, pulse_phase_next;
  logic [TIMER_BITS-1:0] pulse_timer, pulse_timer_next;
  logic [TIMER_BITS-1:0] hold_timer, hold_timer_next;
  logic                  pin_level, pin_level_next;
  logic                  led_level, led_level_next;
  logic                  led_hold, led_hold_next;
  logic                  blinking, blinking_next;
  logic [2:0]            blinks_done, blinks_done_next;
  logic [7:0]            blink_timer, blink_timer_next;
  logic                  request_latched, request_latched_next;
  event_t                ev;
  logic [2:0]            count_min;

  always_comb begin
    primed_next          = primed;
    last_button_next     = last_button;
    pulse_phase_next     = pulse_phase;
    pulse_timer_next     = pulse_timer;
    hold_timer_next      = hold_timer;
    pin_level_next       = pin_level;
    led_level_next       = led_level;
    led_hold_next        = led_hold;
    blinking_next        = blinking;
    blinks_done_next     = blinks_done;
    blink_timer_next     = blink_timer;
    request_latched_next = request_latched;
    ev                   = EV_NONE;
    count_min            = (cfg.blink_count == 3'd0) ? 3'd1 : cfg.blink_count;

    if (request_latched) begin
      // Frozen until reset.
    end else if (blinking) begin
      if (blink_timer > 8'd1) begin
        blink_timer_next = blink_timer - 8'd1;
      end else if (led_level) begin
        led_level_next   = 1'b0;
        blink_timer_next = at_least_one8(cfg.blink_off_ticks);
      end else begin
        blinks_done_next = blinks_done + 3'd1;
        if (blinks_done_next >= count_min) begin
          blinking_next        = 1'b0;
          request_latched_next = 1'b1;
          blink_timer_next     = 8'd0;
        end else begin
          led_level_next   = 1'b1;
          blink_timer_next = at_least_one8(cfg.blink_on_ticks);
        end
      end
    end else if (!primed) begin
      primed_next      = 1'b1;
      last_button_next = button;
    end else begin
      if (button != last_button) begin
        ev               = button ? EV_PRESS : EV_RELEASE;
        last_button_next = button;
      end else if (pulse_timer != '0) begin
        pulse_timer_next = pulse_timer - TIMER_BITS'(1);
        if (pulse_timer_next == '0) begin
          ev = EV_PULSE;
        end
      end else if (hold_timer != '0) begin
        hold_timer_next = hold_timer - TIMER_BITS'(1);
        if (hold_timer_next == '0) begin
          ev = EV_HOLD;
        end
      end

      unique case (ev)
        EV_PRESS: begin
          if (pulse_phase == PH_IDLE) begin
            pulse_timer_next = load_tmr(cfg.pulse_ticks);
            hold_timer_next  = load_tmr(cfg.hold_ticks);
            pin_level_next   = 1'b1;
            led_hold_next    = 1'b1;
            led_level_next   = 1'b1;
            pulse_phase_next = PH_ON;
          end
        end
        EV_RELEASE: begin
          if (pulse_phase == PH_WAIT) begin
            pulse_phase_next = PH_IDLE;
          end
          hold_timer_next = '0;
        end
        EV_PULSE: begin
          pin_level_next   = 1'b0;
          led_level_next   = 1'b0;
          led_hold_next    = 1'b0;
          pulse_phase_next = PH_WAIT;
        end
        EV_HOLD: begin
          led_hold_next    = 1'b1;
          led_level_next   = 1'b1;
          blinking_next    = 1'b1;
          blinks_done_next = 3'd0;
          blink_timer_next = at_least_one8(cfg.blink_on_ticks);
        end
        default: begin
        end
      endcase
    end

    res.ext_reset_pin = pin_level_next;
    res.led_drive     = led_level_next;
    res.led_held      = led_hold_next;
    res.reset_request = request_latched_next;
    res.event_code    = ev;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      primed          <= 1'b0;
      last_button     <= 1'b0;
      pulse_phase     <= PH_IDLE;
      pulse_timer     <= '0;
      hold_timer      <= '0;
      pin_level       <= 1'b1;
      led_level       <= 1'b0;
      led_hold        <= 1'b0;
      blinking        <= 1'b0;
      blinks_done     <= 3'd0;
      blink_timer     <= 8'd0;
      request_latched <= 1'b0;
    end else if (step) begin
      primed          <= primed_next;
      last_button     <= last_button_next;
      pulse_phase     <= pulse_phase_next;
      pulse_timer     <= pulse_timer_next;
      hold_timer      <= hold_timer_next;
      pin_level       <= pin_level_next;
      led_level       <= led_level_next;
      led_hold        <= led_hold_next;
      blinking        <= blinking_next;
      blinks_done     <= blinks_done_next;
      blink_timer     <= blink_timer_next;
      request_latched <= request_latched_next;
    end
  end

  a_request_sticky: assert property (@(posedge clk) disable iff (rst)
    request_latched |=> request_latched)
    else $error("reset request dropped without reset");

  a_blink_or_request: assert property (@(posedge clk) disable iff (rst)
    !(blinking && request_latched))
    else $error("blinking while reset request is latched");

  a_pulse_timer_phase: assert property (@(posedge clk) disable iff (rst)
    (pulse_phase == PH_ON) == (pulse_timer != '0))
    else $error("pulse timer and pulse phase disagree");

endmodule

[rtl/reset_button_controller.sv]
// Push-button reset controller. Each input transaction is one sampling tick whose tdata bit 0
// is the button level; every tick produces exactly one output transaction carrying the reset
// pin level, the LED level and ownership, the sticky system reset request and the event taken
// on that tick. The state update is made of combinational compares and decrements, so one
// tick is accepted every clock cycle unless the skid entry is full; its result is registered
// on the output, and a two-entry output buffer accepts one more tick when the output stalls.
// Configuration registers are written through the cfg channel, which is always ready.
module reset_button_controller
  import rbc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,  // [0] button_pressed, [7:1] zero
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,  // [0] ext_reset_pin, [1] led_drive, [2] led_held,
                                    // [3] reset_request, [6:4] event_code, [7] zero
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [9:0] cfg_data
);

  cfg_t    cfg;
  result_t res;
  result_t out_data;
  result_t skid_data;
  logic    out_valid;
  logic    skid_valid;
  logic    accept;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !skid_valid;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pulse_ticks     <= 10'd10;
      cfg.hold_ticks      <= 10'd100;
      cfg.blink_on_ticks  <= 8'd4;
      cfg.blink_off_ticks <= 8'd6;
      cfg.blink_count     <= 3'd5;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PULSE_TICKS:     cfg.pulse_ticks     <= cfg_data;
        CFG_HOLD_TICKS:      cfg.hold_ticks      <= cfg_data;
        CFG_BLINK_ON_TICKS:  cfg.blink_on_ticks  <= cfg_data[7:0];
        CFG_BLINK_OFF_TICKS: cfg.blink_off_ticks <= cfg_data[7:0];
        CFG_BLINK_COUNT:     cfg.blink_count     <= cfg_data[2:0];
        default: begin
        end
      endcase
    end
  end

  rbc_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (accept),
    .button (s_axis_tdata[0]),
    .cfg    (cfg),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (m_axis_tready || !out_valid) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else if (accept) begin
        out_data  <= res;
        out_valid <= 1'b1;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (accept) begin
      skid_data  <= res;
      skid_valid <= 1'b1;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, out_data.event_code, out_data.reset_request,
                          out_data.led_held, out_data.led_drive, out_data.ext_reset_pin};

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held with empty output register");

  a_no_accept_when_full: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !m_axis_tready) |=> skid_valid && out_valid)
    else $error("buffered result lost while output stalled");

  a_result_move: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && m_axis_tready) |=> out_valid && !skid_valid)
    else $error("buffered result not moved to output");

endmodule

[sim/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import rbc_pkg::*;

  typedef enum logic [1:0] {
    PULSE_IDLE = 2'd0,
    PULSE_ON   = 2'd1,
    PULSE_WAIT = 2'd2
  } pulse_phase_t;

  class tick_outcome_board;
    cfg_t                  regs;
    logic                  primed;
    logic                  last_button;
    pulse_phase_t          phase;
    logic [TIMER_BITS-1:0] pulse_timer;
    logic [TIMER_BITS-1:0] hold_timer;
    logic                  pin_level;
    logic                  led_level;
    logic                  led_hold;
    logic                  blinking;
    logic [2:0]            blinks_done;
    logic [7:0]            blink_timer;
    logic                  request_latched;
    result_t               pending_outcomes[$];
    int                    mismatch_count;

    function new();
      regs.pulse_ticks     = 10'd10;
      regs.hold_ticks      = 10'd100;
      regs.blink_on_ticks  = 8'd4;
      regs.blink_off_ticks = 8'd6;
      regs.blink_count     = 3'd5;
      primed          = 1'b0;
      last_button     = 1'b0;
      phase           = PULSE_IDLE;
      pulse_timer     = '0;
      hold_timer      = '0;
      pin_level       = 1'b1;
      led_level       = 1'b0;
      led_hold        = 1'b0;
      blinking        = 1'b0;
      blinks_done     = 3'd0;
      blink_timer     = 8'd0;
      request_latched = 1'b0;
      mismatch_count  = 0;
    endfunction

    function int nonzero(int v);
      return (v == 0) ? 1 : v;
    endfunction

    function logic [TIMER_BITS-1:0] timer_load(logic [9:0] ticks);
      if (ticks == 10'd0) return TIMER_BITS'(1);
      if (int'(ticks) > int'(TMR_MAX)) return TMR_MAX;
      return TIMER_BITS'(ticks);
    endfunction

    function void set_reg(cfg_index_t idx, logic [9:0] value);
      case (idx)
        CFG_PULSE_TICKS:     regs.pulse_ticks = value;
        CFG_HOLD_TICKS:      regs.hold_ticks = value;
        CFG_BLINK_ON_TICKS:  regs.blink_on_ticks = value[7:0];
        CFG_BLINK_OFF_TICKS: regs.blink_off_ticks = value[7:0];
        CFG_BLINK_COUNT:     regs.blink_count = value[2:0];
        default: ;
      endcase
    endfunction

    function void note_tick(logic btn);
      event_t  ev;
      result_t want;
      ev = EV_NONE;
      if (request_latched) begin
        // The controller stays frozen until the next reset.
      end else if (blinking) begin
        if (blink_timer > 8'd1) begin
          blink_timer = blink_timer - 8'd1;
        end else if (led_level) begin
          led_level   = 1'b0;
          blink_timer = 8'(nonzero(regs.blink_off_ticks));
        end else begin
          blinks_done = blinks_done + 3'd1;
          if (int'(blinks_done) >= nonzero(regs.blink_count)) begin
            blinking        = 1'b0;
            request_latched = 1'b1;
            blink_timer     = 8'd0;
          end else begin
            led_level   = 1'b1;
            blink_timer = 8'(nonzero(regs.blink_on_ticks));
          end
        end
      end else if (!primed) begin
        primed      = 1'b1;
        last_button = btn;
      end else begin
        if (btn != last_button) begin
          ev          = btn ? EV_PRESS : EV_RELEASE;
          last_button = btn;
        end else if (pulse_timer != '0) begin
          pulse_timer = pulse_timer - 1'b1;
          if (pulse_timer == '0) ev = EV_PULSE;
        end else if (hold_timer != '0) begin
          hold_timer = hold_timer - 1'b1;
          if (hold_timer == '0) ev = EV_HOLD;
        end
        case (ev)
          EV_PRESS: begin
            if (phase == PULSE_IDLE) begin
              pulse_timer = timer_load(regs.pulse_ticks);
              hold_timer  = timer_load(regs.hold_ticks);
              pin_level   = 1'b1;
              led_hold    = 1'b1;
              led_level   = 1'b1;
              phase       = PULSE_ON;
            end
          end
          EV_RELEASE: begin
            if (phase == PULSE_WAIT) phase = PULSE_IDLE;
            hold_timer = '0;
          end
          EV_PULSE: begin
            pin_level = 1'b0;
            led_level = 1'b0;
            led_hold  = 1'b0;
            phase     = PULSE_WAIT;
          end
          EV_HOLD: begin
            led_hold    = 1'b1;
            led_level   = 1'b1;
            blinking    = 1'b1;
            blinks_done = 3'd0;
            blink_timer = 8'(nonzero(regs.blink_on_ticks));
          end
          default: ;
        endcase
      end
      want.ext_reset_pin = pin_level;
      want.led_drive     = led_level;
      want.led_held      = led_hold;
      want.reset_request = request_latched;
      want.event_code    = ev;
      pending_outcomes.push_back(want);
    endfunction

    task report_mismatch(string what, int got, int want);
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      mismatch_count++;
    endtask

    task check_outcome(logic [7:0] tdata);
      result_t want;
      if (pending_outcomes.size() == 0) begin
        report_mismatch("unexpected transaction", tdata, 0);
        return;
      end
      want = pending_outcomes.pop_front();
      if (tdata[0] !== want.ext_reset_pin)
        report_mismatch("ext_reset_pin", tdata[0], want.ext_reset_pin);
      if (tdata[1] !== want.led_drive)
        report_mismatch("led_drive", tdata[1], want.led_drive);
      if (tdata[2] !== want.led_held)
        report_mismatch("led_held", tdata[2], want.led_held);
      if (tdata[3] !== want.reset_request)
        report_mismatch("reset_request", tdata[3], want.reset_request);
      if (tdata[6:4] !== want.event_code)
        report_mismatch("event_code", tdata[6:4], want.event_code);
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'd0;   // [0] button_pressed, [7:1] zero
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;          // [0] ext_reset_pin, [1] led_drive, [2] led_held,
                                     // [3] reset_request, [6:4] event_code, [7] zero
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [2:0] cfg_index = CFG_PULSE_TICKS;
  logic [9:0] cfg_data = 10'd0;

  int src_idle = 32;
  int sink_idle = 55;

  tick_outcome_board board;

  bit opening_ticks[19] = '{1, 0, 1, 1, 1, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 1};

  reset_button_controller i_dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (m_axis_tvalid && m_axis_tready) board.check_outcome(m_axis_tdata);
    m_axis_tready <= ($urandom_range(99) >= sink_idle);
  end

  task send_tick(input logic btn);
    while ($urandom_range(99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, btn};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    board.note_tick(btn);
  endtask

  task wait_drained();
    s_axis_tvalid <= 1'b0;
    while (board.pending_outcomes.size() != 0) @(posedge clk);
  endtask

  task write_reg(input cfg_index_t idx, input logic [9:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.set_reg(idx, value);
  endtask

  task apply_settings(input logic [9:0] pulse, input logic [9:0] hold,
                      input logic [7:0] on_ticks, input logic [7:0] off_ticks,
                      input logic [2:0] count);
    wait_drained();
    repeat (2) @(posedge clk);
    write_reg(CFG_PULSE_TICKS, pulse);
    write_reg(CFG_HOLD_TICKS, hold);
    write_reg(CFG_BLINK_ON_TICKS, {2'b00, on_ticks});
    write_reg(CFG_BLINK_OFF_TICKS, {2'b00, off_ticks});
    write_reg(CFG_BLINK_COUNT, {7'd0, count});
    cfg_valid <= 1'b0;
  endtask

  // Drives the button until the pulse machine is idle with the button released.
  task settle_idle();
    while (!(board.primed && board.phase == PULSE_IDLE && !board.last_button))
      send_tick(board.phase == PULSE_WAIT && !board.last_button);
  endtask

  // Press and release runs of random length, with some noisy stretches. The hold timer is
  // never allowed to expire here, since the blink sequence can only end in a frozen state.
  task run_phase(input int n_ticks);
    int   seg_left;
    int   mode;
    int   pulse_len;
    logic level;
    logic noisy;
    logic btn;
    seg_left  = 0;
    level     = 1'b0;
    noisy     = 1'b0;
    pulse_len = int'(board.timer_load(board.regs.pulse_ticks));
    for (int i = 0; i < n_ticks; i++) begin
      if (i == n_ticks / 2) wait_drained();
      if (seg_left == 0) begin
        mode  = $urandom_range(9);
        level = ~level;
        noisy = (mode >= 8);
        if (mode <= 2) seg_left = $urandom_range(1, 4);
        else if (mode <= 5 && pulse_len <= 64) seg_left = pulse_len + $urandom_range(0, 4);
        else seg_left = $urandom_range(1, 40);
      end
      btn = noisy ? 1'($urandom_range(1)) : level;
      seg_left--;
      if (btn && board.last_button && board.pulse_timer == '0 &&
          board.hold_timer == TIMER_BITS'(1))
        btn = 1'b0;
      send_tick(btn);
    end
  endtask

  initial begin
    board = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (opening_ticks[i]) send_tick(opening_ticks[i]);
    run_phase(80);
    apply_settings(10'd1, 10'd1, 8'd1, 8'd1, 3'd1);
    run_phase(100);

    src_idle  = 55;
    sink_idle = 32;
    apply_settings(10'd0, 10'd0, 8'd0, 8'd0, 3'd0);
    run_phase(100);
    apply_settings(10'd1023, 10'd1023, 8'd255, 8'd255, 3'd7);
    settle_idle();
    repeat (170) send_tick(1'b1);
    run_phase(100);

    src_idle  = 0;
    sink_idle = 0;
    apply_settings(10'($urandom_range(1023)), 10'($urandom_range(1023)),
                   8'($urandom_range(255)), 8'($urandom_range(255)), 3'($urandom_range(7)));
    run_phase(150);
    apply_settings(10'($urandom_range(30)), 10'($urandom_range(50)),
                   8'($urandom_range(255)), 8'($urandom_range(255)), 3'($urandom_range(7)));
    run_phase(150);

    apply_settings(10'($urandom_range(12)), 10'($urandom_range(20)),
                   8'($urandom_range(12)), 8'($urandom_range(12)), 3'($urandom_range(7)));
    settle_idle();
    while (!board.request_latched)
      send_tick(board.blinking ? 1'($urandom_range(1)) : 1'b1);
    repeat (20) send_tick(1'($urandom_range(1)));

    s_axis_tvalid <= 1'b0;
    while (board.pending_outcomes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (board.mismatch_count == 0) begin
      $display("** reset_button_controller: PASSED **");
    end else begin
      $display("** reset_button_controller: FAILED **");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("** reset_button_controller: FAILED **");
    $finish;
  end

endmodule
